>>> rtl/ctc_greedy_decoder_defines.svh
// assertion macros used by the decoder top level
`ifndef CTC_GREEDY_DECODER_DEFINES_SVH
`define CTC_GREEDY_DECODER_DEFINES_SVH

// condition that must hold at every edge out of reset
`define CTCGD_ASSERT_NOW(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition that must hold at the edge after a trigger
`define CTCGD_ASSERT_NEXT(name, trig, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

>>> rtl/ctcgd_pkg.sv
package ctcgd_pkg;

	localparam int MAX_CLASSES_DEF = 16384;
	localparam int SCORE_BITS_DEF  = 16;

	localparam int CFG_W           = 15;
	localparam int NUM_CLASSES_RST = 6625;

	// emitted character count and its saturation point
	localparam int              CNT_W       = 11;
	localparam logic [CNT_W-1:0] COUNT_LIMIT = 11'd2047;

	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic accept;
		logic load_new;
		logic load_held;
		logic div_init;
		logic div_step;
		logic load_sum;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic eos;
	} status_t;

endpackage

>>> rtl/ctcgd_ctrl.sv
module ctcgd_ctrl #(
	parameter int SCORE_BITS = ctcgd_pkg::SCORE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ctcgd_pkg::status_t sts,
	output ctcgd_pkg::cmd_t    cmd
);
	import ctcgd_pkg::*;

	localparam int SUM_W = SCORE_BITS + CNT_W;
	localparam int DC_W  = $clog2(SUM_W + 1);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_EMIT,
		ST_DIV,
		ST_SUM
	} state_t;

	state_t          state_q;
	logic            eos_pend_q;
	logic [DC_W-1:0] div_cnt_q;
	logic            out_valid_q;
	logic            out_free;
	logic            any_load;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_RUN);
	assign out_valid = out_valid_q;
	assign any_load  = cmd.load_new || cmd.load_held || cmd.load_sum;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_RUN: begin
				cmd.accept = in_valid;
				if (in_valid && sts.emit && out_free) begin
					cmd.load_new = 1'b1;
					cmd.last     = !sts.eos;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.load_held = 1'b1;
					cmd.last      = !eos_pend_q;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == '0) begin
					cmd.div_init = 1'b1;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_SUM: begin
				if (out_free) begin
					cmd.load_sum = 1'b1;
					cmd.last     = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			eos_pend_q  <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (any_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (cmd.accept) begin
						if (sts.emit && !out_free) begin
							state_q    <= ST_EMIT;
							eos_pend_q <= sts.eos;
						end else if (sts.eos) begin
							state_q   <= ST_DIV;
							div_cnt_q <= '0;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q   <= eos_pend_q ? ST_DIV : ST_RUN;
						div_cnt_q <= '0;
					end
				end
				ST_DIV: begin
					// an init step, then one quotient bit per cycle
					if (div_cnt_q == DC_W'(SUM_W)) begin
						state_q <= ST_SUM;
					end else begin
						div_cnt_q <= div_cnt_q + 1'b1;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

endmodule

>>> rtl/ctcgd_dp.sv
module ctcgd_dp #(
	parameter int MAX_CLASSES = ctcgd_pkg::MAX_CLASSES_DEF,
	parameter int SCORE_BITS  = ctcgd_pkg::SCORE_BITS_DEF,
	localparam int IDX_W      = $clog2(MAX_CLASSES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ctcgd_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic signed [SCORE_BITS-1:0]  score,
	input  logic                          end_of_sequence,
	input  ctcgd_pkg::cmd_t               cmd,
	output ctcgd_pkg::status_t            sts,
	output logic                          kind,
	output logic [IDX_W-1:0]              char_index,
	output logic signed [SCORE_BITS-1:0]  char_score,
	output logic signed [SCORE_BITS-1:0]  average_score,
	output logic [ctcgd_pkg::CNT_W-1:0]   char_count,
	output logic                          last
);
	import ctcgd_pkg::*;

	localparam int N_W   = IDX_W + 1;
	localparam int SUM_W = SCORE_BITS + CNT_W;
	localparam int CW    = (CFG_W > N_W) ? CFG_W : N_W;
	localparam logic [N_W-1:0] N_RST = (NUM_CLASSES_RST > MAX_CLASSES) ?
		N_W'(MAX_CLASSES) : N_W'(NUM_CLASSES_RST);

	// effective class count, clamped when written
	logic [N_W-1:0] n_q;
	logic [N_W-1:0] n_next;
	logic [CW-1:0]  cfg_ext;

	logic [IDX_W-1:0]             pos_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic signed [SCORE_BITS-1:0] best_score_q;
	logic [IDX_W-1:0]             prev_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]             cnt_q;

	logic [IDX_W-1:0]             new_idx;
	logic signed [SCORE_BITS-1:0] new_best;
	logic                         step_end;
	logic                         emit;

	logic [SUM_W-1:0]      quo_q;
	logic [CNT_W-1:0]      rem_q;
	logic                  neg_q;
	logic [SUM_W-1:0]      sum_mag;
	logic [CNT_W:0]        trial;
	logic                  ge;
	logic [CNT_W:0]        trial_sub;
	logic [SCORE_BITS-1:0] q_lo;
	logic [SCORE_BITS-1:0] avg_val;

	logic [IDX_W-1:0]             ch_idx;
	logic signed [SCORE_BITS-1:0] ch_score;

	logic                         kind_q;
	logic [IDX_W-1:0]             idx_q;
	logic signed [SCORE_BITS-1:0] cscore_q;
	logic signed [SCORE_BITS-1:0] avg_q;
	logic [CNT_W-1:0]             ocnt_q;
	logic                         last_q;

	assign cfg_ext = CW'(cfg_wdata);

	always_comb begin
		if (cfg_ext < CW'(2)) begin
			n_next = N_W'(2);
		end else if (cfg_ext > CW'(MAX_CLASSES)) begin
			n_next = N_W'(MAX_CLASSES);
		end else begin
			n_next = N_W'(cfg_ext);
		end
	end

	// running argmax, first maximum wins
	always_comb begin
		if (pos_q == '0) begin
			new_best = score;
			new_idx  = '0;
		end else if (score > best_score_q) begin
			new_best = score;
			new_idx  = pos_q;
		end else begin
			new_best = best_score_q;
			new_idx  = best_idx_q;
		end
	end

	assign step_end = (({1'b0, pos_q} + 1'b1) >= n_q) || end_of_sequence;
	assign emit     = step_end && (new_idx != '0) && (new_idx != prev_q);
	assign sts.emit = emit;
	assign sts.eos  = end_of_sequence;

	// restoring division of |sum| by count
	assign sum_mag   = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign trial     = {rem_q, quo_q[SUM_W-1]};
	assign ge        = (trial >= {1'b0, cnt_q});
	assign trial_sub = trial - {1'b0, cnt_q};
	assign q_lo      = quo_q[SCORE_BITS-1:0];

	always_comb begin
		if (cnt_q == '0) begin
			avg_val = '0;
		end else if (neg_q) begin
			avg_val = ~q_lo + 1'b1;
		end else begin
			avg_val = q_lo;
		end
	end

	assign ch_idx   = cmd.load_held ? best_idx_q : new_idx;
	assign ch_score = cmd.load_held ? best_score_q : new_best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= N_RST;
			pos_q  <= '0;
			prev_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				n_q <= n_next;
			end
			if (cmd.accept) begin
				pos_q <= step_end ? '0 : pos_q + 1'b1;
				if (step_end) begin
					prev_q <= end_of_sequence ? '0 : new_idx;
				end
				if (emit && (cnt_q != COUNT_LIMIT)) begin
					sum_q <= sum_q + SUM_W'(new_best);
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.load_sum) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	// winner stays in the best registers after a step ends until the next score
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			best_score_q <= new_best;
			best_idx_q   <= new_idx;
		end
		if (cmd.div_init) begin
			quo_q <= sum_mag;
			rem_q <= '0;
			neg_q <= sum_q[SUM_W-1];
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
		end
		if (cmd.load_new || cmd.load_held) begin
			kind_q   <= KIND_CHAR;
			idx_q    <= ch_idx;
			cscore_q <= ch_score;
			avg_q    <= '0;
			ocnt_q   <= '0;
			last_q   <= cmd.last;
		end else if (cmd.load_sum) begin
			kind_q   <= KIND_SUMMARY;
			idx_q    <= '0;
			cscore_q <= '0;
			avg_q    <= avg_val;
			ocnt_q   <= cnt_q;
			last_q   <= cmd.last;
		end
	end

	assign kind          = kind_q;
	assign char_index    = idx_q;
	assign char_score    = cscore_q;
	assign average_score = avg_q;
	assign char_count    = ocnt_q;
	assign last          = last_q;

endmodule

>>> rtl/ctc_greedy_decoder.sv
// channel  | handshake               | payload
// ---------+-------------------------+--------------------------------------------------
// input    | in_valid / in_stall     | score, end_of_sequence
// output   | out_valid / out_stall   | kind, char_index, char_score, average_score,
//          |                         | char_count, last
// config   | cfg_we                  | cfg_wdata (num_classes)
//
// one score per cycle while the sequence runs; a score that ends a step and emits
// while the output register is still held stalls the input until that register frees
// end of sequence: serial divider of score sum by count, then the summary loads
// as soon as the output register frees
// arst_n clears the control state and the sequence state at once, no clearing pass
// out_stall only holds the output register; input is stalled while a result waits
// for it or while the divider runs
`include "ctc_greedy_decoder_defines.svh"

module ctc_greedy_decoder #(
	parameter int MAX_CLASSES = ctcgd_pkg::MAX_CLASSES_DEF,
	parameter int SCORE_BITS  = ctcgd_pkg::SCORE_BITS_DEF,
	localparam int IDX_W      = $clog2(MAX_CLASSES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ctcgd_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SCORE_BITS-1:0]  score,
	input  logic                          end_of_sequence,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kind,
	output logic [IDX_W-1:0]              char_index,
	output logic signed [SCORE_BITS-1:0]  char_score,
	output logic signed [SCORE_BITS-1:0]  average_score,
	output logic [ctcgd_pkg::CNT_W-1:0]   char_count,
	output logic                          last
);
	import ctcgd_pkg::*;

	cmd_t    cmd;
	status_t sts;

	ctcgd_ctrl #(
		.SCORE_BITS (SCORE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ctcgd_dp #(
		.MAX_CLASSES (MAX_CLASSES),
		.SCORE_BITS  (SCORE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.score           (score),
		.end_of_sequence (end_of_sequence),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.char_index      (char_index),
		.char_score      (char_score),
		.average_score   (average_score),
		.char_count      (char_count),
		.last            (last)
	);

	// the divider and summary must block input after the sequence ends
	`CTCGD_ASSERT_NEXT(a_eos_blocks_input, in_valid && !in_stall && end_of_sequence, in_stall, "input taken straight after end of sequence")
	`CTCGD_ASSERT_NOW(a_char_not_blank, !(out_valid && kind == KIND_CHAR) || char_index != '0, "blank emitted as character")
	`CTCGD_ASSERT_NOW(a_char_no_summary, !(out_valid && kind == KIND_CHAR) || (char_count == '0 && average_score == '0), "character transaction carries summary fields")
	`CTCGD_ASSERT_NOW(a_summary_last, !(out_valid && kind == KIND_SUMMARY) || (last && char_index == '0), "summary transaction malformed")

endmodule

>>> tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ctcgd_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 48;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_PCT     = 35;
	localparam int PHASE_ITEMS  = 45;

	typedef struct packed {
		logic        kind;
		logic [13:0] char_index;
		logic [15:0] char_score;
		logic [15:0] average_score;
		logic [10:0] char_count;
		logic        last;
	} decode_result_t;

	// greedy best-path decoder: tracks the running argmax and the sequence totals
	class decode_predictor;
		int             classes;
		longint         best_score;
		int             best_index;
		int             position;
		int             prev_winner;
		longint         score_sum;
		int             emitted;
		int             mismatches;
		decode_result_t expected_q[$];

		function new();
			classes     = NUM_CLASSES_RST;
			best_score  = 0;
			best_index  = 0;
			position    = 0;
			prev_winner = 0;
			score_sum   = 0;
			emitted     = 0;
			mismatches  = 0;
		endfunction

		function void set_classes(int value);
			classes = value;
		endfunction

		function void note_score(logic signed [15:0] s, logic eos);
			int             n;
			int             k;
			longint         mean;
			decode_result_t res [2];
			n = classes;
			k = 0;
			if (n < 2)
				n = 2;
			if (n > MAX_CLASSES_DEF)
				n = MAX_CLASSES_DEF;
			if (position == 0) begin
				best_score = s;
				best_index = 0;
			end else if (longint'(s) > best_score) begin
				best_score = s;
				best_index = position;
			end
			position++;
			// step ends on the class count or early on end of sequence
			if (position >= n || eos) begin
				if (best_index != 0 && best_index != prev_winner) begin
					res[k] = '{KIND_CHAR, 14'(best_index), 16'(best_score),
						16'd0, 11'd0, 1'b0};
					k++;
					if (emitted < COUNT_LIMIT) begin
						score_sum += best_score;
						emitted++;
					end
				end
				prev_winner = best_index;
				position    = 0;
				best_score  = 0;
				best_index  = 0;
			end
			if (eos) begin
				mean = (emitted != 0) ? score_sum / emitted : 0;
				res[k] = '{KIND_SUMMARY, 14'd0, 16'd0, 16'(mean), 11'(emitted), 1'b0};
				k++;
				score_sum   = 0;
				emitted     = 0;
				prev_winner = 0;
			end
			for (int i = 0; i < k; i++) begin
				res[i].last = (i == k - 1);
				expected_q.insert(expected_q.size(), res[i]);
			end
		endfunction

		function void check_result(decode_result_t got);
			decode_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: unexpected result kind=%0d index=%0d",
						" score=%0d avg=%0d count=%0d last=%0d"},
						got.kind, got.char_index, $signed(got.char_score),
						$signed(got.average_score), got.char_count, got.last);
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind || got.char_index !== want.char_index ||
					got.char_score !== want.char_score ||
					got.average_score !== want.average_score ||
					got.char_count !== want.char_count || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display({"mismatch at %0t: expected kind=%0d index=%0d",
						" score=%0d avg=%0d count=%0d last=%0d"},
						$realtime, want.kind, want.char_index, $signed(want.char_score),
						$signed(want.average_score), want.char_count, want.last);
					$display({"                 actual   kind=%0d index=%0d",
						" score=%0d avg=%0d count=%0d last=%0d"},
						got.kind, got.char_index, $signed(got.char_score),
						$signed(got.average_score), got.char_count, got.last);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic signed [15:0]  score;
	logic                end_of_sequence;
	logic                out_valid;
	logic                out_stall;
	logic                kind;
	logic [13:0]         char_index;
	logic signed [15:0]  char_score;
	logic signed [15:0]  average_score;
	logic [CNT_W-1:0]    char_count;
	logic                last;

	decode_predictor sb = new();

	bit steady;
	bit hold_go;
	bit hold_started;
	int hold_left;
	int cycles;
	int phase_items;

	ctc_greedy_decoder uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.score          (score),
		.end_of_sequence(end_of_sequence),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.char_index     (char_index),
		.char_score     (char_score),
		.average_score  (average_score),
		.char_count     (char_count),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: checks each output transaction and drives the stall
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				sb.check_result('{kind, char_index, char_score, average_score,
					char_count, last});
			if (hold_go && !hold_started) begin
				hold_started = 1'b1;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic send_item(input logic signed [15:0] s, input logic eos);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		score           <= s;
		end_of_sequence <= eos;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_score(s, eos);
		phase_items++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_class_count(input int value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_classes(value);
	endtask

	function automatic logic signed [15:0] random_score();
		case ($urandom_range(0, 4))
			0: begin
				// narrow range so ties are common
				return 16'($urandom_range(0, 7)) - 16'd4;
			end
			1: begin
				return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			end
			default: begin
				return 16'($urandom());
			end
		endcase
	endfunction

	task automatic random_sequence(input int classes_eff);
		int total;
		// long steps are only reached through an early end of sequence
		if (classes_eff > 16) begin
			total = $urandom_range(1, 12);
		end else begin
			total = $urandom_range(1, 5) * classes_eff;
			if ($urandom_range(0, 3) == 0)
				total = $urandom_range(1, total);
		end
		for (int k = 0; k < total; k++)
			send_item(random_score(), k == total - 1);
	endtask

	initial begin
		int settings [10] = '{1, 2, 3, 7, 16, 2, 6625, 16384, 32767, 0};
		int eff;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		in_valid        <= 1'b0;
		score           <= '0;
		end_of_sequence <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset class count, extremes and a tie on the maximum
		send_item(16'sh8000, 1'b0);
		send_item(16'sh7fff, 1'b0);
		send_item(16'sh7fff, 1'b0);
		send_item(16'sd100, 1'b1);
		// end of sequence on the first score: blank wins, empty summary
		send_item(16'sd0, 1'b1);

		// class count below range acts as two; negative mean truncates toward zero
		set_class_count(0);
		send_item(-16'sd5, 1'b0);
		send_item(-16'sd3, 1'b0);
		send_item(16'sd7, 1'b0);
		send_item(16'sd7, 1'b0);
		send_item(16'sh8000, 1'b0);
		send_item(-16'sd2, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(16'sd4, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(16'sd6, 1'b0);
		send_item(16'sd1, 1'b1);

		// class count lowered part way through a step
		set_class_count(5);
		send_item(16'sd2, 1'b0);
		send_item(16'sd9, 1'b0);
		send_item(16'sd4, 1'b0);
		set_class_count(2);
		send_item(16'sd1, 1'b0);
		send_item(16'sd3, 1'b1);

		// largest class count and a value above it, ended early
		set_class_count(16384);
		send_item(16'sd0, 1'b0);
		send_item(16'sd5, 1'b1);
		set_class_count(32767);
		send_item(-16'sd1, 1'b0);
		send_item(-16'sd2, 1'b0);
		send_item(16'sd3, 1'b1);

		foreach (settings[i]) begin
			set_class_count(settings[i]);
			eff = settings[i] < 2 ? 2 :
				(settings[i] > MAX_CLASSES_DEF ? MAX_CLASSES_DEF : settings[i]);
			if (i == 2 || i == 3)
				steady = 1'b1;
			if (i == 2)
				hold_go = 1'b1;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				random_sequence(eff);
			steady = 1'b0;
		end

		drain_results();
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> ctc_greedy_decoder.f
+incdir+rtl
rtl/ctcgd_pkg.sv
rtl/ctcgd_ctrl.sv
rtl/ctcgd_dp.sv
rtl/ctc_greedy_decoder.sv
tb/tb.sv
